[rtl/sclp_pkg.sv]
// shared types and constants for the serial command line parser
package sclp_pkg;

   // result kinds
   localparam logic [2:0] KIND_ECHO_BYTE = 3'd0;
   localparam logic [2:0] KIND_ECHO_EOL  = 3'd1;
   localparam logic [2:0] KIND_COMMAND   = 3'd2;
   localparam logic [2:0] KIND_NAME      = 3'd3;
   localparam logic [2:0] KIND_ERROR     = 3'd4;

   // command codes
   localparam logic [2:0] CMD_OPEN  = 3'd0;
   localparam logic [2:0] CMD_PLAY  = 3'd1;
   localparam logic [2:0] CMD_PAUSE = 3'd2;
   localparam logic [2:0] CMD_STOP  = 3'd3;
   localparam logic [2:0] CMD_CLOSE = 3'd4;
   localparam logic [2:0] CMD_DEBUG = 3'd5;
   localparam logic [2:0] CMD_NONE  = 3'd7;

   // line field being typed
   localparam logic [1:0] PHASE_LETTER  = 2'd0;
   localparam logic [1:0] PHASE_CHANNEL = 2'd1;
   localparam logic [1:0] PHASE_NAME    = 2'd2;

   // characters
   localparam logic [7:0] CHAR_BACKSPACE = 8'h08;
   localparam logic [7:0] CHAR_TAB       = 8'h09;
   localparam logic [7:0] CHAR_LF        = 8'h0A;
   localparam logic [7:0] CHAR_CR        = 8'h0D;
   localparam logic [7:0] CHAR_SPACE     = 8'h20;
   localparam logic [7:0] CHAR_PLUS      = 8'h2B;
   localparam logic [7:0] CHAR_MINUS     = 8'h2D;
   localparam logic [7:0] CHAR_ZERO      = 8'h30;
   localparam logic [7:0] CHAR_NINE      = 8'h39;
   localparam logic [7:0] CHAR_LOWER_A   = 8'h61;
   localparam logic [7:0] CHAR_LOWER_C   = 8'h63;
   localparam logic [7:0] CHAR_LOWER_D   = 8'h64;
   localparam logic [7:0] CHAR_LOWER_O   = 8'h6F;
   localparam logic [7:0] CHAR_LOWER_P   = 8'h70;
   localparam logic [7:0] CHAR_LOWER_S   = 8'h73;

   // controller to datapath commands
   typedef struct packed {
      logic       accept;
      logic       edit;
      logic [1:0] phase;
      logic       walk_step;
      logic       set_pending;
      logic       clr_chan;
      logic       load_chan;
      logic       set_name_len;
      logic       toggle_debug;
      logic       fail;
      logic       name_start;
      logic       name_next;
      logic       out_load;
      logic [2:0] out_kind;
      logic       out_last;
   } sclp_cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic       echo_en;
      logic       eol;
      logic       term;
      logic       is_space;
      logic [2:0] code;
      logic [2:0] pending;
      logic       walk_more;
      logic       chan_zero;
      logic       name_len_zero;
      logic       name_last;
   } sclp_status_type;

endpackage

[rtl/sclp_datapath.sv]
// datapath: field buffers, channel decoder, name store and result register
module sclp_datapath #(
   parameter int CMD_BUF_LEN   = 10,
   parameter int DIGIT_BUF_LEN = 10,
   parameter int NAME_BUF_LEN  = 20
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [7:0]             req_rx_byte,
   input  sclp_pkg::sclp_cmd_type cmd,
   output sclp_pkg::sclp_status_type status,
   output logic [2:0]             rsp_kind,
   output logic [7:0]             rsp_byte_value,
   output logic [2:0]             rsp_command_code,
   output logic signed [15:0]     rsp_channel_number,
   output logic                   rsp_last
);

   localparam int MAX_A   = (CMD_BUF_LEN > DIGIT_BUF_LEN) ? CMD_BUF_LEN : DIGIT_BUF_LEN;
   localparam int MAX_LEN = (MAX_A > NAME_BUF_LEN) ? MAX_A : NAME_BUF_LEN;
   localparam int FILL_W  = $clog2(MAX_LEN + 1);
   localparam int DIDX_W  = $clog2(DIGIT_BUF_LEN);
   localparam int NIDX_W  = $clog2(NAME_BUF_LEN);

   localparam logic [FILL_W-1:0] CAP_CMD   = FILL_W'(CMD_BUF_LEN);
   localparam logic [FILL_W-1:0] CAP_DIGIT = FILL_W'(DIGIT_BUF_LEN);
   localparam logic [FILL_W-1:0] CAP_NAME  = FILL_W'(NAME_BUF_LEN);

   // received beat and line state
   logic [7:0]        rx_ff;
   logic              echo_en_ff;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic [FILL_W-1:0] len_ff, len_in;
   logic [7:0]        first_letter_ff, first_letter_in;
   logic [2:0]        pending_ff, pending_in;
   logic [15:0]       parsed_ff, parsed_in;
   logic [NIDX_W-1:0] name_len_ff, name_len_in;
   logic              debug_ff, debug_in;

   // channel decoder
   logic [DIDX_W-1:0] walk_idx_ff, walk_idx_in;
   logic [15:0]       walk_val_ff, walk_val_in;
   logic              walk_neg_ff, walk_neg_in;
   logic              walk_sign_seen_ff, walk_sign_seen_in;
   logic              walk_done_ff, walk_done_in;
   logic [7:0]        walk_rd_ff;

   // name read-out
   logic [NIDX_W-1:0] name_idx_ff, name_idx_in;
   logic [7:0]        name_rd_ff;

   // stores
   logic [7:0] digit_store [DIGIT_BUF_LEN];
   logic [7:0] name_store  [NAME_BUF_LEN];

   // edit signals
   logic [FILL_W-1:0] cap;
   logic [FILL_W-1:0] fill_edit;
   logic              is_bs;
   logic              room;
   logic              eol;
   logic              term;
   logic              wr_digit;
   logic              wr_name;
   logic [2:0]        letter_code;
   logic [15:0]       walk_chan;

   // walker classification
   logic        d_blank, d_sign, d_digit;
   logic [15:0] d_acc;

   function automatic logic [2:0] letter_to_code(input logic [7:0] c);
      logic [2:0] r;
      case (c)
         sclp_pkg::CHAR_LOWER_O: r = sclp_pkg::CMD_OPEN;
         sclp_pkg::CHAR_LOWER_P: r = sclp_pkg::CMD_PLAY;
         sclp_pkg::CHAR_LOWER_A: r = sclp_pkg::CMD_PAUSE;
         sclp_pkg::CHAR_LOWER_S: r = sclp_pkg::CMD_STOP;
         sclp_pkg::CHAR_LOWER_C: r = sclp_pkg::CMD_CLOSE;
         sclp_pkg::CHAR_LOWER_D: r = sclp_pkg::CMD_DEBUG;
         default:                r = sclp_pkg::CMD_NONE;
      endcase
      return r;
   endfunction

   // byte classification and field edit
   always_comb begin
      case (cmd.phase)
         sclp_pkg::PHASE_CHANNEL: cap = CAP_DIGIT;
         sclp_pkg::PHASE_NAME:    cap = CAP_NAME;
         default:                 cap = CAP_CMD;
      endcase
      is_bs = rx_ff == sclp_pkg::CHAR_BACKSPACE;
      eol   = (rx_ff == sclp_pkg::CHAR_CR) || (rx_ff == sclp_pkg::CHAR_LF);
      term  = eol || ((rx_ff == sclp_pkg::CHAR_SPACE) && (cmd.phase != sclp_pkg::PHASE_NAME));
      room  = fill_ff < cap;
      if (is_bs) begin
         fill_edit = (fill_ff != '0) ? fill_ff - 1'b1 : fill_ff;
      end else if (room) begin
         fill_edit = fill_ff + 1'b1;
      end else begin
         fill_edit = fill_ff;
      end
      wr_digit = cmd.edit && !is_bs && room && (cmd.phase == sclp_pkg::PHASE_CHANNEL);
      wr_name  = cmd.edit && !is_bs && room && (cmd.phase == sclp_pkg::PHASE_NAME);
   end

   // walker step over one stored channel byte
   always_comb begin
      d_blank = (walk_rd_ff == sclp_pkg::CHAR_SPACE) ||
                (walk_rd_ff inside {[sclp_pkg::CHAR_TAB:sclp_pkg::CHAR_CR]});
      d_sign  = walk_rd_ff inside {sclp_pkg::CHAR_PLUS, sclp_pkg::CHAR_MINUS};
      d_digit = walk_rd_ff inside {[sclp_pkg::CHAR_ZERO:sclp_pkg::CHAR_NINE]};
      d_acc   = (walk_val_ff << 3) + (walk_val_ff << 1) +
                {8'h00, walk_rd_ff - sclp_pkg::CHAR_ZERO};
      walk_chan = walk_neg_ff ? 16'(16'd0 - walk_val_ff) : walk_val_ff;
   end

   // next state of the registers
   always_comb begin
      fill_in           = fill_ff;
      len_in            = len_ff;
      first_letter_in   = first_letter_ff;
      pending_in        = pending_ff;
      parsed_in         = parsed_ff;
      name_len_in       = name_len_ff;
      debug_in          = debug_ff;
      walk_idx_in       = walk_idx_ff;
      walk_val_in       = walk_val_ff;
      walk_neg_in       = walk_neg_ff;
      walk_sign_seen_in = walk_sign_seen_ff;
      walk_done_in      = walk_done_ff;
      name_idx_in       = name_idx_ff;

      if (cmd.accept) begin
         walk_idx_in       = '0;
         walk_val_in       = '0;
         walk_neg_in       = 1'b0;
         walk_sign_seen_in = 1'b0;
         walk_done_in      = 1'b0;
      end

      if (cmd.edit) begin
         if (!is_bs && room && (cmd.phase == sclp_pkg::PHASE_LETTER) && (fill_ff == '0)) begin
            first_letter_in = rx_ff;
         end
         len_in  = (fill_edit != '0) ? fill_edit - 1'b1 : '0;
         fill_in = term ? '0 : fill_edit;
      end

      // one stored byte of the channel field per step
      if (cmd.walk_step) begin
         if (!walk_sign_seen_ff && d_blank) begin
            walk_idx_in = walk_idx_ff + 1'b1;
         end else if (!walk_sign_seen_ff && d_sign) begin
            walk_neg_in       = walk_rd_ff == sclp_pkg::CHAR_MINUS;
            walk_sign_seen_in = 1'b1;
            walk_idx_in       = walk_idx_ff + 1'b1;
         end else if (d_digit) begin
            walk_val_in       = d_acc;
            walk_sign_seen_in = 1'b1;
            walk_idx_in       = walk_idx_ff + 1'b1;
         end else begin
            walk_done_in = 1'b1;
         end
      end

      // line outcome
      if (cmd.set_pending) begin
         pending_in = letter_code;
      end
      if (cmd.clr_chan) begin
         parsed_in = '0;
      end
      if (cmd.load_chan) begin
         parsed_in = walk_chan;
      end
      if (cmd.set_name_len) begin
         name_len_in = len_ff[NIDX_W-1:0];
      end
      if (cmd.toggle_debug) begin
         debug_in = !debug_ff;
      end
      if (cmd.fail) begin
         pending_in = sclp_pkg::CMD_OPEN;
         parsed_in  = '0;
      end

      if (cmd.name_start) begin
         name_idx_in = '0;
      end else if (cmd.name_next) begin
         name_idx_in = name_idx_ff + 1'b1;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff         <= '0;
         first_letter_ff <= '0;
         pending_ff      <= sclp_pkg::CMD_OPEN;
         parsed_ff       <= '0;
         name_len_ff     <= '0;
         debug_ff        <= 1'b0;
      end else begin
         fill_ff         <= fill_in;
         first_letter_ff <= first_letter_in;
         pending_ff      <= pending_in;
         parsed_ff       <= parsed_in;
         name_len_ff     <= name_len_in;
         debug_ff        <= debug_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         rx_ff      <= req_rx_byte;
         echo_en_ff <= debug_ff;
      end
      len_ff            <= len_in;
      walk_idx_ff       <= walk_idx_in;
      walk_val_ff       <= walk_val_in;
      walk_neg_ff       <= walk_neg_in;
      walk_sign_seen_ff <= walk_sign_seen_in;
      walk_done_ff      <= walk_done_in;
      name_idx_ff       <= name_idx_in;
   end

   // digit store, one write and one registered read
   always_ff @(posedge clock) begin
      if (wr_digit) begin
         digit_store[fill_ff[DIDX_W-1:0]] <= rx_ff;
      end
      walk_rd_ff <= digit_store[walk_idx_ff];
   end

   // name store, one write and one registered read
   always_ff @(posedge clock) begin
      if (wr_name) begin
         name_store[fill_ff[NIDX_W-1:0]] <= rx_ff;
      end
      name_rd_ff <= name_store[name_idx_ff];
   end

   // result register
   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_kind <= cmd.out_kind;
         rsp_last <= cmd.out_last;
         case (cmd.out_kind)
            sclp_pkg::KIND_ECHO_BYTE: rsp_byte_value <= rx_ff;
            sclp_pkg::KIND_NAME:      rsp_byte_value <= name_rd_ff;
            default:                  rsp_byte_value <= '0;
         endcase
         if (cmd.out_kind == sclp_pkg::KIND_COMMAND) begin
            rsp_command_code   <= pending_ff;
            rsp_channel_number <= parsed_ff;
         end else begin
            rsp_command_code   <= '0;
            rsp_channel_number <= '0;
         end
      end
   end

   // status to the controller
   always_comb begin
      letter_code           = (len_ff == FILL_W'(1)) ? letter_to_code(first_letter_ff)
                                                     : sclp_pkg::CMD_NONE;
      status.echo_en        = echo_en_ff;
      status.eol            = eol;
      status.term           = term;
      status.is_space       = rx_ff == sclp_pkg::CHAR_SPACE;
      status.code           = letter_code;
      status.pending        = pending_ff;
      status.walk_more      = !walk_done_ff && (FILL_W'(walk_idx_ff) < len_ff);
      status.chan_zero      = walk_val_ff == '0;
      status.name_len_zero  = name_len_ff == '0;
      status.name_last      = NIDX_W'(name_idx_ff + 1'b1) == name_len_ff;
   end

endmodule

[rtl/sclp_control.sv]
// controller: sequences edit, channel decode, line outcome and result beats
module sclp_control (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   input  sclp_pkg::sclp_status_type status,
   output sclp_pkg::sclp_cmd_type    cmd
);

   localparam logic [3:0] ST_IDLE      = 4'd0;
   localparam logic [3:0] ST_EDIT      = 4'd1;
   localparam logic [3:0] ST_WALK_RD   = 4'd2;
   localparam logic [3:0] ST_WALK_STEP = 4'd3;
   localparam logic [3:0] ST_DECIDE    = 4'd4;
   localparam logic [3:0] ST_ECHO      = 4'd5;
   localparam logic [3:0] ST_CMD       = 4'd6;
   localparam logic [3:0] ST_NAME_RD   = 4'd7;
   localparam logic [3:0] ST_NAME_OUT  = 4'd8;
   localparam logic [3:0] ST_ERR       = 4'd9;

   logic [3:0] state_ff, state_in;
   logic [1:0] phase_ff, phase_in;
   logic       valid_ff, valid_in;
   logic       exec_ff, exec_in;
   logic       fail_ff, fail_in;
   logic       open_ff, open_in;

   // line outcome
   logic       exec;
   logic       fail;
   logic [1:0] phase_next;
   logic       set_pending;
   logic       clr_chan;
   logic       load_chan;
   logic       set_name_len;
   logic [2:0] eff_code;
   logic       out_free;
   logic       accept;

   assign accept    = req_valid && (state_ff == ST_IDLE);
   assign out_free  = !valid_ff || !rsp_stall;
   assign req_stall = state_ff != ST_IDLE;
   assign rsp_valid = valid_ff;

   // outcome of a terminated field
   always_comb begin
      exec         = 1'b0;
      fail         = 1'b0;
      phase_next   = phase_ff;
      set_pending  = 1'b0;
      clr_chan     = 1'b0;
      load_chan    = 1'b0;
      set_name_len = 1'b0;
      eff_code     = (phase_ff == sclp_pkg::PHASE_LETTER) ? status.code : status.pending;
      if (status.term) begin
         case (phase_ff)
            sclp_pkg::PHASE_LETTER: begin
               if (status.code == sclp_pkg::CMD_NONE) begin
                  fail = 1'b1;
               end else begin
                  set_pending = 1'b1;
                  clr_chan    = 1'b1;
                  if (status.code == sclp_pkg::CMD_DEBUG) begin
                     exec = 1'b1;
                  end else if (status.is_space) begin
                     phase_next = sclp_pkg::PHASE_CHANNEL;
                  end else if (status.code == sclp_pkg::CMD_OPEN) begin
                     fail = 1'b1;
                  end else begin
                     exec = 1'b1;
                  end
               end
            end
            sclp_pkg::PHASE_CHANNEL: begin
               load_chan = 1'b1;
               if (status.chan_zero) begin
                  fail = 1'b1;
               end else if (status.is_space) begin
                  if (status.pending == sclp_pkg::CMD_OPEN) begin
                     phase_next = sclp_pkg::PHASE_NAME;
                  end else begin
                     fail = 1'b1;
                  end
               end else begin
                  exec = 1'b1;
               end
            end
            sclp_pkg::PHASE_NAME: begin
               set_name_len = 1'b1;
               exec         = 1'b1;
            end
            default: begin
               fail = 1'b1;
            end
         endcase
      end
      if (exec || fail) begin
         phase_next = sclp_pkg::PHASE_LETTER;
      end
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      exec_in  = exec_ff;
      fail_in  = fail_ff;
      open_in  = open_ff;
      valid_in = valid_ff && rsp_stall;
      cmd      = '0;
      cmd.phase = phase_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd.accept = 1'b1;
               state_in   = ST_EDIT;
            end
         end
         ST_EDIT: begin
            cmd.edit = 1'b1;
            if (status.term && (phase_ff == sclp_pkg::PHASE_CHANNEL)) begin
               state_in = ST_WALK_RD;
            end else begin
               state_in = ST_DECIDE;
            end
         end
         ST_WALK_RD: begin
            state_in = status.walk_more ? ST_WALK_STEP : ST_DECIDE;
         end
         ST_WALK_STEP: begin
            cmd.walk_step = 1'b1;
            state_in      = ST_WALK_RD;
         end
         ST_DECIDE: begin
            cmd.set_pending  = set_pending;
            cmd.clr_chan     = clr_chan;
            cmd.load_chan    = load_chan;
            cmd.set_name_len = set_name_len;
            cmd.toggle_debug = exec && (eff_code == sclp_pkg::CMD_DEBUG);
            cmd.fail         = fail;
            phase_in = phase_next;
            exec_in  = exec;
            fail_in  = fail;
            open_in  = eff_code == sclp_pkg::CMD_OPEN;
            if (status.echo_en) begin
               state_in = ST_ECHO;
            end else if (exec) begin
               state_in = ST_CMD;
            end else if (fail) begin
               state_in = ST_ERR;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_ECHO: begin
            if (out_free) begin
               cmd.out_load = 1'b1;
               cmd.out_kind = status.eol ? sclp_pkg::KIND_ECHO_EOL : sclp_pkg::KIND_ECHO_BYTE;
               cmd.out_last = !(exec_ff || fail_ff);
               valid_in     = 1'b1;
               if (exec_ff) begin
                  state_in = ST_CMD;
               end else if (fail_ff) begin
                  state_in = ST_ERR;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_CMD: begin
            if (out_free) begin
               cmd.out_load = 1'b1;
               cmd.out_kind = sclp_pkg::KIND_COMMAND;
               cmd.out_last = !(open_ff && !status.name_len_zero);
               valid_in     = 1'b1;
               if (open_ff && !status.name_len_zero) begin
                  cmd.name_start = 1'b1;
                  state_in       = ST_NAME_RD;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_NAME_RD: begin
            state_in = ST_NAME_OUT;
         end
         ST_NAME_OUT: begin
            if (out_free) begin
               cmd.out_load = 1'b1;
               cmd.out_kind = sclp_pkg::KIND_NAME;
               cmd.out_last = status.name_last;
               valid_in     = 1'b1;
               if (status.name_last) begin
                  state_in = ST_IDLE;
               end else begin
                  cmd.name_next = 1'b1;
                  state_in      = ST_NAME_RD;
               end
            end
         end
         ST_ERR: begin
            if (out_free) begin
               cmd.out_load = 1'b1;
               cmd.out_kind = sclp_pkg::KIND_ERROR;
               cmd.out_last = 1'b1;
               valid_in     = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         phase_ff <= sclp_pkg::PHASE_LETTER;
         valid_ff <= 1'b0;
         exec_ff  <= 1'b0;
         fail_ff  <= 1'b0;
         open_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         valid_ff <= valid_in;
         exec_ff  <= exec_in;
         fail_ff  <= fail_in;
         open_ff  <= open_in;
      end
   end

endmodule

[rtl/serial_command_line_parser.sv]
// serial command line parser top level: controller plus datapath
// one byte is taken at a time; a plain byte passes the edit and decide states, and an echo state with echo on
// a channel terminator walks the digit store with a read and a step state per stored byte, then a last read
// the first result beat follows the edit, decide and any walk states; echo and command beats
// then come one a cycle while results do not stall, and each name byte follows a read state
// synchronous reset clears the line state and debug echo; no clearing pass is needed
module serial_command_line_parser #(
   parameter int CMD_BUF_LEN   = 10,
   parameter int DIGIT_BUF_LEN = 10,
   parameter int NAME_BUF_LEN  = 20
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [7:0]         req_rx_byte,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [2:0]         rsp_kind,
   output logic [7:0]         rsp_byte_value,
   output logic [2:0]         rsp_command_code,
   output logic signed [15:0] rsp_channel_number,
   output logic               rsp_last
);

   sclp_pkg::sclp_cmd_type    cmd;
   sclp_pkg::sclp_status_type status;

   // sequencing
   sclp_control u_control (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // buffers, decoder and result register
   sclp_datapath #(
      .CMD_BUF_LEN   (CMD_BUF_LEN),
      .DIGIT_BUF_LEN (DIGIT_BUF_LEN),
      .NAME_BUF_LEN  (NAME_BUF_LEN)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .req_rx_byte        (req_rx_byte),
      .cmd                (cmd),
      .status             (status),
      .rsp_kind           (rsp_kind),
      .rsp_byte_value     (rsp_byte_value),
      .rsp_command_code   (rsp_command_code),
      .rsp_channel_number (rsp_channel_number),
      .rsp_last           (rsp_last)
   );

endmodule

[rtl/sclp_checker.sv]
// port checker for the serial command line parser, bound to the top level
module sclp_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_stall,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic [2:0]         rsp_kind,
   input logic [7:0]         rsp_byte_value,
   input logic [2:0]         rsp_command_code,
   input logic signed [15:0] rsp_channel_number,
   input logic               rsp_last
);

   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_kind) &&
      $stable(rsp_byte_value) && $stable(rsp_command_code) &&
      $stable(rsp_channel_number) && $stable(rsp_last))
      else $error("result beat changed while stalled");

   // one byte at a time: the input stalls right after a beat is taken
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("input taken while a byte is still in work");

   // only command beats carry a command code and channel
   a_non_command_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind != sclp_pkg::KIND_COMMAND) |->
      (rsp_command_code == 3'd0) && (rsp_channel_number == 16'sd0))
      else $error("command fields set on a non-command beat");

   // an error always closes the byte's results
   a_error_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == sclp_pkg::KIND_ERROR) |-> rsp_last)
      else $error("error beat not marked last");

endmodule

bind serial_command_line_parser sclp_checker u_sclp_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_valid),
   .req_stall          (req_stall),
   .rsp_valid          (rsp_valid),
   .rsp_stall          (rsp_stall),
   .rsp_kind           (rsp_kind),
   .rsp_byte_value     (rsp_byte_value),
   .rsp_command_code   (rsp_command_code),
   .rsp_channel_number (rsp_channel_number),
   .rsp_last           (rsp_last)
);

[dv/tb_serial_command_line_parser.sv]
// self-checking testbench for the serial command line parser
module tb_serial_command_line_parser;

   localparam int CMD_LEN        = 10;
   localparam int DIGIT_LEN      = 10;
   localparam int NAME_LEN       = 20;
   localparam int RANDOM_TARGET  = 120;
   localparam int DRAIN_CYCLES   = 120;
   localparam int WATCHDOG_LIMIT = 4000;

   // command field of results that carry no command
   localparam logic [2:0] CODE_UNUSED    = 3'd0;
   localparam logic [7:0] CHAR_VTAB      = 8'h0B;
   localparam logic [7:0] CHAR_FORMFEED  = 8'h0C;

   typedef struct packed {
      logic [2:0]         kind;
      logic [7:0]         byte_value;
      logic [2:0]         command_code;
      logic signed [15:0] channel_number;
      logic               last;
   } line_result_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [7:0]         req_rx_byte = 8'h00;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [2:0]         rsp_kind;
   logic [7:0]         rsp_byte_value;
   logic [2:0]         rsp_command_code;
   logic signed [15:0] rsp_channel_number;
   logic               rsp_last;

   // mirror of the parser line state
   logic [1:0]  line_phase = sclp_pkg::PHASE_LETTER;
   int unsigned field_fill = 0;
   logic [7:0]  letter_byte = 8'h00;
   logic [2:0]  pend_cmd = sclp_pkg::CMD_OPEN;
   logic [15:0] chan_value = 16'h0000;
   logic [7:0]  digit_buf [DIGIT_LEN] = '{default: 8'h00};
   logic [7:0]  name_buf [NAME_LEN] = '{default: 8'h00};
   int unsigned name_count = 0;
   logic        echo_on = 1'b0;

   line_result_type pending_results [$];
   int unsigned     bytes_sent = 0;
   int              error_count = 0;
   int              quiet_cycles = 0;
   bit              sender_calm = 1'b0;
   bit              steady = 1'b0;

   logic [7:0] command_letters [6] = '{sclp_pkg::CHAR_LOWER_O, sclp_pkg::CHAR_LOWER_P,
                                       sclp_pkg::CHAR_LOWER_A, sclp_pkg::CHAR_LOWER_S,
                                       sclp_pkg::CHAR_LOWER_C, sclp_pkg::CHAR_LOWER_D};
   logic [7:0] blank_chars [3] = '{sclp_pkg::CHAR_TAB, CHAR_VTAB, CHAR_FORMFEED};

   serial_command_line_parser #(
      .CMD_BUF_LEN   (CMD_LEN),
      .DIGIT_BUF_LEN (DIGIT_LEN),
      .NAME_BUF_LEN  (NAME_LEN)
   ) uut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_rx_byte        (req_rx_byte),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_kind           (rsp_kind),
      .rsp_byte_value     (rsp_byte_value),
      .rsp_command_code   (rsp_command_code),
      .rsp_channel_number (rsp_channel_number),
      .rsp_last           (rsp_last)
   );

   always #10 clock = ~clock;

   function automatic line_result_type make_result(input logic [2:0] kind,
                                                   input logic [7:0] value,
                                                   input logic [2:0] code,
                                                   input logic [15:0] chan);
      line_result_type r;
      r.kind           = kind;
      r.byte_value     = value;
      r.command_code   = code;
      r.channel_number = chan;
      r.last           = 1'b0;
      return r;
   endfunction

   function automatic logic [2:0] letter_to_cmd(input logic [7:0] c);
      case (c)
         sclp_pkg::CHAR_LOWER_O: return sclp_pkg::CMD_OPEN;
         sclp_pkg::CHAR_LOWER_P: return sclp_pkg::CMD_PLAY;
         sclp_pkg::CHAR_LOWER_A: return sclp_pkg::CMD_PAUSE;
         sclp_pkg::CHAR_LOWER_S: return sclp_pkg::CMD_STOP;
         sclp_pkg::CHAR_LOWER_C: return sclp_pkg::CMD_CLOSE;
         sclp_pkg::CHAR_LOWER_D: return sclp_pkg::CMD_DEBUG;
         default:                return sclp_pkg::CMD_NONE;
      endcase
   endfunction

   // decimal read: leading blanks, optional sign, digits, 16-bit wrap
   function automatic logic [15:0] decode_channel(input int unsigned count);
      int unsigned i;
      logic [15:0] v;
      logic        neg;
      i   = 0;
      v   = 16'h0000;
      neg = 1'b0;
      while (i < count && (digit_buf[i] == sclp_pkg::CHAR_SPACE ||
             (digit_buf[i] >= sclp_pkg::CHAR_TAB && digit_buf[i] <= sclp_pkg::CHAR_CR)))
         i++;
      if (i < count && (digit_buf[i] == sclp_pkg::CHAR_PLUS ||
                        digit_buf[i] == sclp_pkg::CHAR_MINUS)) begin
         neg = (digit_buf[i] == sclp_pkg::CHAR_MINUS);
         i++;
      end
      while (i < count && digit_buf[i] >= sclp_pkg::CHAR_ZERO &&
             digit_buf[i] <= sclp_pkg::CHAR_NINE) begin
         v = v * 16'd10 + 16'(digit_buf[i] - sclp_pkg::CHAR_ZERO);
         i++;
      end
      return neg ? 16'd0 - v : v;
   endfunction

   // work out the results one accepted byte causes and queue them
   task automatic parse_rx_byte(input logic [7:0] c);
      line_result_type burst [$];
      line_result_type res;
      logic            eol, term, run_cmd, bad_line;
      logic [2:0]      code;
      int unsigned     cap, content, i;
      eol      = (c == sclp_pkg::CHAR_CR) || (c == sclp_pkg::CHAR_LF);
      term     = eol || (c == sclp_pkg::CHAR_SPACE && line_phase != sclp_pkg::PHASE_NAME);
      cap      = (line_phase == sclp_pkg::PHASE_CHANNEL) ? DIGIT_LEN :
                 (line_phase == sclp_pkg::PHASE_NAME) ? NAME_LEN : CMD_LEN;
      run_cmd  = 1'b0;
      bad_line = 1'b0;

      // echo comes ahead of everything else
      if (echo_on)
         burst.push_back(make_result(eol ? sclp_pkg::KIND_ECHO_EOL : sclp_pkg::KIND_ECHO_BYTE,
                                     eol ? 8'h00 : c, CODE_UNUSED, 16'h0000));

      // field edit; bytes past the buffer are dropped
      if (c == sclp_pkg::CHAR_BACKSPACE) begin
         if (field_fill > 0)
            field_fill--;
      end else if (field_fill < cap) begin
         case (line_phase)
            sclp_pkg::PHASE_CHANNEL: digit_buf[field_fill] = c;
            sclp_pkg::PHASE_NAME:    name_buf[field_fill] = c;
            default:                 if (field_fill == 0) letter_byte = c;
         endcase
         field_fill++;
      end

      // field completion
      if (term) begin
         content    = (field_fill > 0) ? field_fill - 1 : 0;
         field_fill = 0;
         if (line_phase == sclp_pkg::PHASE_CHANNEL) begin
            chan_value = decode_channel(content);
            if (chan_value == 16'h0000)
               bad_line = 1'b1;
            else if (c == sclp_pkg::CHAR_SPACE) begin
               if (pend_cmd == sclp_pkg::CMD_OPEN)
                  line_phase = sclp_pkg::PHASE_NAME;
               else
                  bad_line = 1'b1;
            end else
               run_cmd = 1'b1;
         end else if (line_phase == sclp_pkg::PHASE_NAME) begin
            name_count = content;
            run_cmd    = 1'b1;
         end else begin
            code       = (content == 1) ? letter_to_cmd(letter_byte) : sclp_pkg::CMD_NONE;
            chan_value = 16'h0000;
            if (code == sclp_pkg::CMD_NONE)
               bad_line = 1'b1;
            else begin
               pend_cmd = code;
               if (code == sclp_pkg::CMD_DEBUG)
                  run_cmd = 1'b1;
               else if (c == sclp_pkg::CHAR_SPACE)
                  line_phase = sclp_pkg::PHASE_CHANNEL;
               else if (code == sclp_pkg::CMD_OPEN)
                  bad_line = 1'b1;
               else
                  run_cmd = 1'b1;
            end
         end
      end

      // command with name bytes, or error
      if (run_cmd) begin
         if (pend_cmd == sclp_pkg::CMD_DEBUG)
            echo_on = ~echo_on;
         burst.push_back(make_result(sclp_pkg::KIND_COMMAND, 8'h00, pend_cmd, chan_value));
         if (pend_cmd == sclp_pkg::CMD_OPEN)
            for (i = 0; i < name_count; i++)
               burst.push_back(make_result(sclp_pkg::KIND_NAME, name_buf[i], CODE_UNUSED,
                                           16'h0000));
         line_phase = sclp_pkg::PHASE_LETTER;
      end else if (bad_line) begin
         burst.push_back(make_result(sclp_pkg::KIND_ERROR, 8'h00, CODE_UNUSED, 16'h0000));
         pend_cmd   = sclp_pkg::CMD_OPEN;
         chan_value = 16'h0000;
         line_phase = sclp_pkg::PHASE_LETTER;
      end

      for (i = 0; i < burst.size(); i++) begin
         res      = burst[i];
         res.last = (i == burst.size() - 1);
         pending_results.push_back(res);
      end
   endtask

   // one input beat, with an occasional gap in front
   task automatic send_byte(input logic [7:0] value);
      if (!steady && !sender_calm && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= value;
      do @(posedge clock); while (req_stall !== 1'b0);
      parse_rx_byte(value);
      bytes_sent++;
   endtask

   task automatic send_text(input string s);
      int i;
      for (i = 0; i < s.len(); i++)
         send_byte(s[i]);
   endtask

   function automatic logic [7:0] random_eol();
      return ($urandom_range(0, 1) == 1) ? sclp_pkg::CHAR_CR : sclp_pkg::CHAR_LF;
   endfunction

   // random byte that neither ends nor edits a field
   function automatic logic [7:0] random_byte(input bit allow_space);
      logic [7:0] v;
      do v = 8'($urandom_range(0, 255));
      while (v == sclp_pkg::CHAR_CR || v == sclp_pkg::CHAR_LF ||
             v == sclp_pkg::CHAR_BACKSPACE ||
             (!allow_space && v == sclp_pkg::CHAR_SPACE));
      return v;
   endfunction

   // mostly well-formed lines with random content, some noise and broken lines
   task automatic send_random_line();
      logic [7:0]  letter;
      int unsigned n, k;
      sender_calm = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 9) == 0) begin
         n = $urandom_range(1, 6);
         for (k = 0; k < n; k++)
            send_byte(8'($urandom_range(0, 255)));
         send_byte(random_eol());
         return;
      end
      letter = ($urandom_range(0, 11) == 0) ? 8'($urandom_range(0, 255)) :
               command_letters[$urandom_range(0, 5)];
      if ($urandom_range(0, 7) == 0) begin
         send_byte(random_byte(1'b0));
         send_byte(sclp_pkg::CHAR_BACKSPACE);
      end
      send_byte(letter);
      if (letter == sclp_pkg::CHAR_LOWER_D) begin
         send_byte(($urandom_range(0, 2) == 0) ? sclp_pkg::CHAR_SPACE : random_eol());
         return;
      end
      if ($urandom_range(0, 4) == 0) begin
         send_byte(random_eol());
         return;
      end
      send_byte(sclp_pkg::CHAR_SPACE);

      // channel field
      if ($urandom_range(0, 4) == 0) begin
         n = $urandom_range(1, 2);
         for (k = 0; k < n; k++)
            send_byte(blank_chars[$urandom_range(0, 2)]);
      end
      case ($urandom_range(0, 5))
         0: send_byte(sclp_pkg::CHAR_PLUS);
         1: send_byte(sclp_pkg::CHAR_MINUS);
         default: ;
      endcase
      n = ($urandom_range(0, 7) == 0) ? $urandom_range(4, 12) : $urandom_range(1, 3);
      for (k = 0; k < n; k++)
         send_byte(sclp_pkg::CHAR_ZERO + 8'($urandom_range(0, 9)));
      if ($urandom_range(0, 9) == 0)
         send_byte(random_byte(1'b0));

      // open usually carries a name
      if (letter == sclp_pkg::CHAR_LOWER_O && $urandom_range(0, 3) != 0) begin
         send_byte(sclp_pkg::CHAR_SPACE);
         n = ($urandom_range(0, 7) == 0) ? $urandom_range(18, 24) : $urandom_range(0, 6);
         for (k = 0; k < n; k++)
            send_byte(($urandom_range(0, 15) == 0) ? sclp_pkg::CHAR_BACKSPACE
                                                   : random_byte(1'b1));
         send_byte(random_eol());
      end else
         send_byte(($urandom_range(0, 7) == 0) ? sclp_pkg::CHAR_SPACE : random_eol());
   endtask

   // open with a name typed with both byte extremes, the second taken back by a backspace
   task automatic test_open_with_name();
      send_text("o 7 ");
      send_byte(8'h00);
      send_byte(8'hFF);
      send_byte(sclp_pkg::CHAR_BACKSPACE);
      send_text("z\n");
   endtask

   // open ended by return after a channel repeats the last name
   task automatic test_open_repeats_name();
      send_text("o 3\r");
   endtask

   // debug on, echoed bad letter, debug off by a space
   task automatic test_debug_echo();
      send_text("d\r?\nd ");
   endtask

   task automatic test_zero_channel();
      send_text("a 0\r");
   endtask

   task automatic test_open_needs_channel();
      send_text("o\r");
   endtask

   // letter, name and channel fields overrunning their buffers
   task automatic test_field_overflow();
      int unsigned k;
      for (k = 0; k < CMD_LEN + 1; k++)
         send_byte(sclp_pkg::CHAR_LOWER_P);
      send_byte(sclp_pkg::CHAR_CR);
      send_text("o 1 ");
      for (k = 0; k < NAME_LEN + 2; k++)
         send_byte(random_byte(1'b1));
      send_byte(random_eol());
      send_text("s -");
      for (k = 0; k < DIGIT_LEN + 1; k++)
         send_byte(sclp_pkg::CHAR_ZERO + 8'($urandom_range(1, 9)));
      send_byte(sclp_pkg::CHAR_CR);
   endtask

   task automatic test_random_lines();
      while (bytes_sent < RANDOM_TARGET)
         send_random_line();
   endtask

   // closing stretch with no gaps and no stalls
   task automatic test_steady_stream();
      steady = 1'b1;
      repeat (6) send_random_line();
   endtask

   // receiver stall bursts with occasional calm stretches
   initial begin
      forever begin
         @(posedge clock);
         if (!steady && $urandom_range(0, 3) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 11)) @(posedge clock);
            rsp_stall <= 1'b0;
         end else if (!steady && $urandom_range(0, 30) == 0)
            repeat ($urandom_range(20, 60)) @(posedge clock);
      end
   end

   task automatic report_field(input string field, input logic [15:0] want,
                               input logic [15:0] got);
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
      error_count++;
   endtask

   // compare each result beat with the oldest expectation
   always @(posedge clock) begin
      line_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual kind %0h byte %0h",
                     $time, rsp_kind, rsp_byte_value);
            error_count++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_kind !== want.kind)
               report_field("kind", 16'(want.kind), 16'(rsp_kind));
            if (rsp_byte_value !== want.byte_value)
               report_field("byte_value", 16'(want.byte_value), 16'(rsp_byte_value));
            if (rsp_command_code !== want.command_code)
               report_field("command_code", 16'(want.command_code), 16'(rsp_command_code));
            if (rsp_channel_number !== want.channel_number)
               report_field("channel_number", want.channel_number, rsp_channel_number);
            if (rsp_last !== want.last)
               report_field("last", 16'(want.last), 16'(rsp_last));
         end
      end
   end

   // watchdog on cycles with no beat on either side
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles <= 0;
      else if (quiet_cycles == WATCHDOG_LIMIT) begin
         $display("serial_command_line_parser test failed");
         $finish;
      end else
         quiet_cycles <= quiet_cycles + 1;
   end

   // test sequence
   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      test_open_with_name();
      test_open_repeats_name();
      test_debug_echo();
      test_zero_channel();
      test_open_needs_channel();
      test_field_overflow();
      test_random_lines();
      test_steady_stream();
      req_valid <= 1'b0;
      while (pending_results.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("serial_command_line_parser test passed");
      else
         $display("serial_command_line_parser test failed");
      $finish;
   end

endmodule

[sim.f]
rtl/sclp_pkg.sv
rtl/sclp_datapath.sv
rtl/sclp_control.sv
rtl/serial_command_line_parser.sv
rtl/sclp_checker.sv
dv/tb_serial_command_line_parser.sv
